// ----- design/pmnc_pkg.sv -----
`timescale 1ns / 1ps

package pmnc_pkg;

  localparam int COLOR_W = 8;
  localparam int DIST_W  = 18;
  localparam int BOUND_W = 19;

  localparam logic [BOUND_W-1:0] START_BOUND = 19'd500000;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

endpackage

// ----- design/palette_midpoint_nearest_color_unit.sv -----
`timescale 1ns / 1ps
// Load transfer: writes the palette entry and gives no result; in_stall stays low.
// Query transfer: reads the two named entries, forms their midpoint, then scans the
// palette, reading one entry per cycle from the single read port of the palette memory.
// Throughput: a query holds in_stall high until its result is loaded into the output
// register, which may wait on out_stall; one load per cycle while no query is in progress.
// rst (synchronous, active high) clears the sequencer, the output valid flag and
// the per-entry valid bits, so every palette entry reads as zero until loaded.

module palette_midpoint_nearest_color_unit
  import pmnc_pkg::*;
#(
  parameter int PALETTE_SIZE = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         action,
  input  logic [7:0]   entry_index,
  input  logic [7:0]   red,
  input  logic [7:0]   green,
  input  logic [7:0]   blue,
  input  logic [7:0]   first_index,
  input  logic [7:0]   second_index,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   nearest_index
);

  localparam int IW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(PALETTE_SIZE - 1);
  localparam logic [8:0]    LAST_9   = 9'(PALETTE_SIZE - 1);
  localparam logic [8:0]    SIZE_9   = 9'(PALETTE_SIZE);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDA   = 3'd1;
  localparam logic [2:0] S_RDB   = 3'd2;
  localparam logic [2:0] S_MID   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state;
  logic [2:0]          state_next;

  rgb_t                pal [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] vld;
  rgb_t                rd_data;
  logic                rd_vld;
  logic [IW-1:0]       rd_addr;
  rgb_t                pix;

  logic [IW-1:0]       fi;
  logic [IW-1:0]       si;
  logic [IW-1:0]       cnt;
  rgb_t                ea;
  rgb_t                mid;

  logic                s1_v;
  logic [IW-1:0]       s1_idx;
  logic                s2_v;
  logic [IW-1:0]       s2_idx;
  logic [DIST_W-1:0]   s2_dist;
  logic [DIST_W-1:0]   scan_dist;

  logic [BOUND_W-1:0]  best_dist;
  logic [IW-1:0]       best_idx;

  logic                in_xfer;
  logic                out_free;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // palette memory
  always_ff @(posedge clk) begin
    if (in_xfer && action == ACT_LOAD && {1'b0, entry_index} < SIZE_9) begin
      pal[entry_index[IW-1:0]] <= '{r: red, g: green, b: blue};
    end
    rd_data <= pal[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (in_xfer && action == ACT_LOAD && {1'b0, entry_index} < SIZE_9) begin
        vld[entry_index[IW-1:0]] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign pix = rd_vld ? rd_data : '0;

  always_comb begin
    case (state)
      S_RDA:   rd_addr = fi;
      S_RDB:   rd_addr = si;
      default: rd_addr = cnt;
    endcase
  end

  assign scan_dist = DIST_W'(sq_diff(pix.r, mid.r)) + DIST_W'(sq_diff(pix.g, mid.g))
                   + DIST_W'(sq_diff(pix.b, mid.b));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_xfer && action == ACT_QUERY) state_next = S_RDA;
      S_RDA:   state_next = S_RDB;
      S_RDB:   state_next = S_MID;
      S_MID:   state_next = S_SCAN;
      S_SCAN:  if (cnt == LAST_IDX) state_next = S_DRAIN;
      S_DRAIN: if (!s1_v && !s2_v) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      s1_v  <= (state == S_SCAN);
      s2_v  <= s1_v;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fi <= ({1'b0, first_index}  > LAST_9) ? LAST_IDX : first_index[IW-1:0];
      si <= ({1'b0, second_index} > LAST_9) ? LAST_IDX : second_index[IW-1:0];
    end
    if (state == S_RDB) begin
      ea <= pix;
    end
    if (state == S_MID) begin
      mid.r <= COLOR_W'(({1'b0, ea.r} + {1'b0, pix.r}) >> 1);
      mid.g <= COLOR_W'(({1'b0, ea.g} + {1'b0, pix.g}) >> 1);
      mid.b <= COLOR_W'(({1'b0, ea.b} + {1'b0, pix.b}) >> 1);
      cnt       <= '0;
      best_dist <= START_BOUND;
      best_idx  <= '0;
    end
    if (state == S_SCAN) begin
      cnt <= cnt + 1'b1;
    end
    s1_idx <= cnt;
    if (s1_v) begin
      s2_dist <= scan_dist;
      s2_idx  <= s1_idx;
    end
    if (s2_v && {1'b0, s2_dist} < best_dist) begin
      best_dist <= {1'b0, s2_dist};
      best_idx  <= s2_idx;
    end
    if (state == S_DONE && out_free) begin
      nearest_index <= 8'(best_idx);
    end
  end

endmodule

// ----- design/pmnc_checker.sv -----
`timescale 1ns / 1ps

module pmnc_checker
  import pmnc_pkg::*;
#(
  parameter int PALETTE_SIZE = 256
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       action,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] nearest_index
);

  localparam logic [8:0] SIZE_9 = 9'(PALETTE_SIZE);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(nearest_index))
    else $error("stalled result changed");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_QUERY |=> in_stall)
    else $error("query transfer did not start a scan");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, nearest_index} < SIZE_9)
    else $error("result index beyond palette");

  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a query in progress");

endmodule

bind palette_midpoint_nearest_color_unit pmnc_checker #(
  .PALETTE_SIZE(PALETTE_SIZE)
) u_pmnc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .action        (action),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .nearest_index (nearest_index)
);

// ----- sim/tb_palette_midpoint_nearest_color_unit.sv -----
`timescale 1ns / 1ps

module tb_palette_midpoint_nearest_color_unit;
  import pmnc_pkg::*;

  localparam int PAL_SIZE    = 256;
  localparam int IDLE_PCT    = 31;
  localparam int RAND_ITEMS  = 600;
  localparam int HOLD_CYCLES = 2000;

  typedef struct packed {
    logic       action;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] first_index;
    logic [7:0] second_index;
  } palette_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       action = ACT_LOAD;
  logic [7:0] entry_index = '0;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic [7:0] first_index = '0;
  logic [7:0] second_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] nearest_index;

  palette_item_t pending_items[$];
  palette_item_t next_item;
  logic [7:0]    expected_nearest[$];
  rgb_t          palette_copy[PAL_SIZE];
  int            fail_count = 0;
  int            n_accepted = 0;
  int            hold_left = 0;
  bit            hold_done = 1'b0;
  bit            calm;

  palette_midpoint_nearest_color_unit #(
    .PALETTE_SIZE(PAL_SIZE)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .entry_index  (entry_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .first_index  (first_index),
    .second_index (second_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .nearest_index(nearest_index)
  );

  // no idling on either side for a stretch of transfers
  assign calm = (n_accepted >= 150) && (n_accepted < 260);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int sq_dist(input logic [7:0] a, input logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  function automatic logic [7:0] clamp_slot(input logic [7:0] idx);
    return (int'(idx) > PAL_SIZE - 1) ? 8'(PAL_SIZE - 1) : idx;
  endfunction

  function automatic logic [7:0] nearest_to_midpoint(input logic [7:0] a_idx,
                                                     input logic [7:0] b_idx);
    rgb_t       ea;
    rgb_t       eb;
    logic [8:0] mr;
    logic [8:0] mg;
    logic [8:0] mb;
    int         best_dist;
    int         cand_dist;
    logic [7:0] best_idx;
    ea = palette_copy[clamp_slot(a_idx)];
    eb = palette_copy[clamp_slot(b_idx)];
    mr = ({1'b0, ea.r} + {1'b0, eb.r}) >> 1;
    mg = ({1'b0, ea.g} + {1'b0, eb.g}) >> 1;
    mb = ({1'b0, ea.b} + {1'b0, eb.b}) >> 1;
    best_dist = int'(START_BOUND);
    best_idx  = '0;
    for (int p = 0; p < PAL_SIZE; p++) begin
      cand_dist = sq_dist(palette_copy[p].r, mr[7:0]) + sq_dist(palette_copy[p].g, mg[7:0])
                + sq_dist(palette_copy[p].b, mb[7:0]);
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best_idx  = 8'(p);
      end
    end
    return best_idx;
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      5: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_load(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                          input logic [7:0] b);
    palette_item_t it;
    it.action       = ACT_LOAD;
    it.entry_index  = idx;
    it.red          = r;
    it.green        = g;
    it.blue         = b;
    it.first_index  = 8'($urandom_range(255));
    it.second_index = 8'($urandom_range(255));
    pending_items.push_back(it);
  endtask

  task automatic add_query(input logic [7:0] a_idx, input logic [7:0] b_idx);
    palette_item_t it;
    it.action       = ACT_QUERY;
    it.entry_index  = 8'($urandom_range(255));
    it.red          = 8'($urandom_range(255));
    it.green        = 8'($urandom_range(255));
    it.blue         = 8'($urandom_range(255));
    it.first_index  = a_idx;
    it.second_index = b_idx;
    pending_items.push_back(it);
  endtask

  // palette copy and expected results, updated on every accepted input transfer
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      n_accepted <= n_accepted + 1;
      if (action == ACT_LOAD) begin
        if (int'(entry_index) < PAL_SIZE)
          palette_copy[entry_index] = '{r: red, g: green, b: blue};
      end else begin
        expected_nearest.push_back(nearest_to_midpoint(first_index, second_index));
      end
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_item = pending_items.pop_front();
        in_valid     <= 1'b1;
        action       <= next_item.action;
        entry_index  <= next_item.entry_index;
        red          <= next_item.red;
        green        <= next_item.green;
        blue         <= next_item.blue;
        first_index  <= next_item.first_index;
        second_index <= next_item.second_index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= 400) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_nearest.size() == 0) begin
        $error("unexpected result transfer: nearest_index actual %0d", nearest_index);
        fail_count++;
      end else if (nearest_index !== expected_nearest[0]) begin
        $error("nearest_index mismatch: expected %0d, actual %0d",
               expected_nearest[0], nearest_index);
        fail_count++;
        void'(expected_nearest.pop_front());
      end else begin
        void'(expected_nearest.pop_front());
      end
    end
  end

  initial begin
    for (int i = 0; i < PAL_SIZE; i++) palette_copy[i] = '0;

    // empty palette, ties everywhere
    add_query(8'd0, 8'd0);
    add_query(8'd255, 8'd255);
    add_load(8'd0, 8'd255, 8'd255, 8'd255);
    add_load(8'd255, 8'd0, 8'd0, 8'd0);
    add_query(8'd0, 8'd255);
    add_query(8'd255, 8'd0);
    add_load(8'd1, 8'hAA, 8'h55, 8'hAA);
    add_load(8'd2, 8'h55, 8'hAA, 8'h55);
    add_query(8'd1, 8'd2);
    add_load(8'd128, 8'd127, 8'd127, 8'd127);
    add_query(8'd1, 8'd2);
    add_load(8'd129, 8'd127, 8'd127, 8'd127);
    add_query(8'd2, 8'd1);
    add_load(8'd254, 8'd1, 8'd0, 8'd0);
    add_load(8'd253, 8'd0, 8'd0, 8'd1);
    add_query(8'd254, 8'd253);
    add_load(8'd0, 8'd255, 8'd0, 8'd0);
    add_query(8'd0, 8'd0);
    add_load(8'd3, 8'd0, 8'd255, 8'd0);
    add_load(8'd4, 8'd0, 8'd0, 8'd255);
    add_query(8'd3, 8'd4);
    add_query(8'd128, 8'd129);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if ($urandom_range(99) < 45)
        add_load(8'($urandom_range(255)), pick_level(), pick_level(), pick_level());
      else
        add_query(8'($urandom_range(255)), 8'($urandom_range(255)));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_nearest.size() != 0) @(posedge clk);
    repeat (PAL_SIZE + 16) @(posedge clk);

    if (expected_nearest.size() != 0) begin
      $error("%0d expected results never arrived", expected_nearest.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
